// ----- rtl/accs_pkg.sv -----
`timescale 1ns / 1ps

package accs_pkg;

    localparam int RESIDUE_W = 5;
    localparam int PROP_W    = 17;
    localparam int MASK_W    = 32;
    localparam int SYM_W     = 8;
    localparam int POP_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 57;

    localparam logic [PROP_W-1:0]    SUM_ONE         = 17'h10000;
    localparam logic [CFG_IDX_W-1:0] IDX_DEFAULT_SYM = 3'd7;
    localparam logic [SYM_W-1:0]     DEFAULT_SYM_RST = 8'd32;

    // rule register packing
    localparam int THR_LSB = 32;
    localparam int SYM_LSB = 49;

    typedef struct packed {
        logic                 valid;
        logic [RESIDUE_W-1:0] residue;
        logic [PROP_W-1:0]    prop;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [PROP_W-1:0] sum;
        logic [POP_W-1:0]  pop;
        logic [SYM_W-1:0]  sym;
    } best_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [PROP_W-1:0] thr;
        logic [SYM_W-1:0]  sym;
        logic [POP_W-1:0]  pop;
    } rule_t;

endpackage

// ----- rtl/accs_cell.sv -----
`timescale 1ns / 1ps

// One rule: accumulates its column sum and, when the column end passes,
// folds its own candidate into the running best record.
module accs_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  accs_pkg::rule_t       rule,
    input  accs_pkg::item_t       item_in,
    input  accs_pkg::best_t       best_in,
    output accs_pkg::item_t       item_out,
    output accs_pkg::best_t       best_out
);

    logic [accs_pkg::PROP_W-1:0] sum_reg, sum_next;
    logic                        touched_reg, touched_next;
    accs_pkg::item_t             item_reg;
    accs_pkg::best_t             best_reg, best_next;

    logic                          covers;
    logic [accs_pkg::PROP_W:0]     sum_wide;
    logic [accs_pkg::PROP_W-1:0]   sum_final;
    logic                          touched_final;
    logic                          match;
    logic [accs_pkg::PROP_W+accs_pkg::POP_W-1:0] lhs, rhs;
    logic                          better;

    always_comb
    begin
        covers        = item_in.valid && rule.mask[item_in.residue];
        sum_wide      = {1'b0, sum_reg} + {1'b0, item_in.prop};
        sum_final     = sum_reg;
        if (covers)
        begin
            sum_final = (sum_wide > {1'b0, accs_pkg::SUM_ONE}) ? accs_pkg::SUM_ONE
                                                               : sum_wide[accs_pkg::PROP_W-1:0];
        end
        touched_final = touched_reg || covers;
        match         = touched_final && (rule.pop != '0) && (sum_final >= rule.thr);

        // sum/pop compared against best_sum/best_pop without division
        lhs    = sum_final * best_in.pop;
        rhs    = best_in.sum * rule.pop;
        better = match && (!best_in.valid || (lhs > rhs));

        best_next = best_in;
        if (item_in.valid && item_in.last && better)
        begin
            best_next.valid = 1'b1;
            best_next.sum   = sum_final;
            best_next.pop   = rule.pop;
            best_next.sym   = rule.sym;
        end

        sum_next     = sum_final;
        touched_next = touched_final;
        if (item_in.valid && item_in.last)
        begin
            sum_next     = '0;
            touched_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            touched_reg <= 1'b0;
            item_reg    <= '0;
        end
        else if (advance)
        begin
            sum_reg     <= sum_next;
            touched_reg <= touched_next;
            item_reg    <= item_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            best_reg <= best_next;
        end
    end

    assign item_out = item_reg;
    assign best_out = best_reg;

endmodule

// ----- rtl/alignment_column_consensus_symbol_core.sv -----
`timescale 1ns / 1ps

// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-----------------------------------------
// s_axis   | in  | s_tvalid/s_tready  | s_tdata: residue, proportion; s_tlast
// m_axis   | out | m_tvalid/m_tready  | m_tdata: symbol; m_tuser: matched
// cfg      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while the row is not held. Items walk the row of rule
// cells, one cell register after another, and a column's result is offered on
// m_tvalid from the output register once its last item reaches the end of the row.
// Reset clears all sums, rules to zero and the default symbol to 32.
// The row holds only while a result sits at its end and the output register
// is still occupied and not being taken; otherwise items are taken while a
// result waits.
module alignment_column_consensus_symbol_core
#(
    parameter int NUM_RULES     = 7,
    parameter int ALPHABET_SIZE = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // residue[4:0], proportion[21:5]
    input  logic                            s_tlast,   // column_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // symbol[7:0]
    output logic                            m_tuser,   // matched
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [accs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [accs_pkg::CFG_W-1:0]      cfg_data
);

    localparam logic [accs_pkg::MASK_W-1:0] ALPHA_MASK =
        {accs_pkg::MASK_W{1'b1}} >> (accs_pkg::MASK_W - ALPHABET_SIZE);

    accs_pkg::rule_t                rules_reg [NUM_RULES];
    logic [accs_pkg::SYM_W-1:0]     default_sym_reg;
    accs_pkg::item_t                item_link [NUM_RULES+1];
    accs_pkg::best_t                best_link [NUM_RULES+1];

    logic                           advance;
    logic                           tail_res;
    logic                           out_valid_reg;
    logic [accs_pkg::SYM_W-1:0]     out_sym_reg;
    logic                           out_matched_reg;
    logic [accs_pkg::MASK_W-1:0]    cfg_mask;

    assign cfg_ready = 1'b1;
    assign cfg_mask  = cfg_data[accs_pkg::MASK_W-1:0] & ALPHA_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RULES; i++)
            begin
                rules_reg[i] <= '0;
            end
            default_sym_reg <= accs_pkg::DEFAULT_SYM_RST;
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < NUM_RULES; i++)
            begin
                if (cfg_index == accs_pkg::CFG_IDX_W'(i))
                begin
                    rules_reg[i].mask <= cfg_mask;
                    rules_reg[i].thr  <= cfg_data[accs_pkg::SYM_LSB-1:accs_pkg::THR_LSB];
                    rules_reg[i].sym  <= cfg_data[accs_pkg::CFG_W-1:accs_pkg::SYM_LSB];
                    rules_reg[i].pop  <= accs_pkg::POP_W'($countones(cfg_mask));
                end
            end
            if (cfg_index == accs_pkg::IDX_DEFAULT_SYM)
            begin
                default_sym_reg <= cfg_data[accs_pkg::SYM_W-1:0];
            end
        end
    end

    assign tail_res = item_link[NUM_RULES].valid && item_link[NUM_RULES].last;
    assign advance  = !(tail_res && out_valid_reg && !m_tready);
    assign s_tready = advance;

    assign item_link[0] = '{valid:   s_tvalid && advance,
                            residue: s_tdata[4:0],
                            prop:    s_tdata[21:5],
                            last:    s_tlast};
    assign best_link[0] = '0;

    for (genvar g = 0; g < NUM_RULES; g++)
    begin : g_cell
        accs_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .rule     (rules_reg[g]),
            .item_in  (item_link[g]),
            .best_in  (best_link[g]),
            .item_out (item_link[g+1]),
            .best_out (best_link[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && tail_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_res)
        begin
            out_matched_reg <= best_link[NUM_RULES].valid;
            out_sym_reg     <= best_link[NUM_RULES].valid ? best_link[NUM_RULES].sym
                                                          : default_sym_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = out_matched_reg;

endmodule

// ----- rtl/accs_checker.sv -----
`timescale 1ns / 1ps

module accs_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [accs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [accs_pkg::CFG_W-1:0]      cfg_data
);

    logic [3:0]                 pending_reg;
    logic [accs_pkg::SYM_W-1:0] dflt_reg;
    logic                       s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // columns ended but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(s_acc && s_tlast) - 4'(m_acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg <= accs_pkg::DEFAULT_SYM_RST;
        end
        else if (cfg_valid && cfg_ready && cfg_index == accs_pkg::IDX_DEFAULT_SYM)
        begin
            dflt_reg <= cfg_data[accs_pkg::SYM_W-1:0];
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result without a finished column");

    a_default: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == dflt_reg)
        else $error("unmatched column lacks default symbol");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held back without output stall");

endmodule

bind alignment_column_consensus_symbol_core accs_checker u_accs_checker (.*);

// ----- sim/alignment_column_consensus_symbol_core_tb.sv -----
`timescale 1ns / 1ps

module alignment_column_consensus_symbol_core_tb;

    localparam int NUM_RULES      = 7;
    localparam int SETTLE_CYCLES  = 24;   // row depth is NUM_RULES + 1
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_COLUMN = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DIRECTED_ROWS  = 19;

    localparam logic [accs_pkg::CFG_IDX_W-1:0] IDX_RULE0 = '0;

    typedef logic [accs_pkg::CFG_W-1:0] rule_word_t;

    typedef struct packed {
        logic [accs_pkg::SYM_W-1:0] symbol;
        logic                       matched;
    } consensus_t;

    typedef struct packed {
        logic [1:0]                     phase;
        logic [accs_pkg::RESIDUE_W-1:0] residue;
        logic [accs_pkg::PROP_W-1:0]    prop;
        logic                           col_end;
        logic                           typed;
        consensus_t                     want;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [23:0]                       s_tdata = '0;
    logic                              s_tlast = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [7:0]                        m_tdata;
    logic                              m_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [accs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [accs_pkg::CFG_W-1:0]        cfg_data = '0;

    // predictor state
    rule_word_t                  rule_reg [NUM_RULES];
    logic [accs_pkg::SYM_W-1:0]  default_sym_reg;
    logic [accs_pkg::PROP_W-1:0] col_sum [NUM_RULES];
    logic                        col_touched [NUM_RULES];
    consensus_t                  pending_consensus [$];

    // staging for the next register load
    rule_word_t                  rule_next [NUM_RULES];
    logic [accs_pkg::SYM_W-1:0]  default_next;

    bit  calm = 1'b0;
    bit  hold_started = 1'b0;
    int  hold_left = 0;
    int  errors = 0;
    int  items_in = 0;
    int  columns_checked = 0;
    int  matched_columns = 0;
    int  stall_cycles = 0;
    int  cfg_loads = 0;
    int  cycle_count = 0;
    consensus_t want_rx;

    // phase, residue, proportion, end, typed, {symbol, matched}
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{2'd0, 5'd0,  17'd65536,  1'b1, 1'b1, '{8'd32, 1'b0}},
        '{2'd0, 5'd31, 17'd0,      1'b0, 1'b0, '{8'd0,  1'b0}},
        '{2'd0, 5'd5,  17'd131071, 1'b1, 1'b1, '{8'd32, 1'b0}},
        '{2'd1, 5'd2,  17'd0,      1'b1, 1'b1, '{8'h5A, 1'b1}},
        '{2'd1, 5'd31, 17'd131071, 1'b0, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd31, 17'd131071, 1'b1, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd0,  17'd20000,  1'b0, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd1,  17'd20000,  1'b1, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd0,  17'd10000,  1'b1, 1'b1, '{8'h2E, 1'b0}},
        '{2'd1, 5'd3,  17'd200,    1'b0, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd4,  17'd200,    1'b1, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd3,  17'd300,    1'b1, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd7,  17'd65536,  1'b1, 1'b1, '{8'h2E, 1'b0}},
        '{2'd1, 5'd2,  17'd5,      1'b0, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd17, 17'd1000,   1'b0, 1'b0, '{8'd0,  1'b0}},
        '{2'd1, 5'd0,  17'd40000,  1'b1, 1'b0, '{8'd0,  1'b0}},
        '{2'd2, 5'd9,  17'd65536,  1'b1, 1'b1, '{8'h00, 1'b0}},
        '{2'd3, 5'd16, 17'd1,      1'b0, 1'b0, '{8'd0,  1'b0}},
        '{2'd3, 5'd31, 17'd65535,  1'b1, 1'b0, '{8'd0,  1'b0}}
    };

    alignment_column_consensus_symbol_core #(
        .NUM_RULES     (NUM_RULES),
        .ALPHABET_SIZE (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic rule_word_t make_rule(input logic [accs_pkg::MASK_W-1:0] mask,
                                             input logic [accs_pkg::PROP_W-1:0] thr,
                                             input logic [accs_pkg::SYM_W-1:0] sym);
        return {sym, thr, mask};
    endfunction

    // Folds one item into the column sums; returns 1 with the consensus on column end.
    function automatic bit consensus_step(input logic [accs_pkg::RESIDUE_W-1:0] residue,
                                          input logic [accs_pkg::PROP_W-1:0] prop,
                                          input logic col_end,
                                          output consensus_t res);
        int                          best;
        longint unsigned             best_sum;
        longint unsigned             best_pop;
        longint unsigned             pop;
        longint unsigned             wide_sum;
        logic [accs_pkg::MASK_W-1:0] mask;
        logic [accs_pkg::PROP_W-1:0] thr;
        res = '0;
        best = -1;
        best_sum = 0;
        best_pop = 1;
        for (int i = 0; i < NUM_RULES; i++)
        begin
            mask = rule_reg[i][accs_pkg::MASK_W-1:0];
            if (mask[residue])
            begin
                wide_sum = longint'(col_sum[i]) + longint'(prop);
                col_sum[i] = (wide_sum > accs_pkg::SUM_ONE) ? accs_pkg::SUM_ONE
                                                            : wide_sum[accs_pkg::PROP_W-1:0];
                col_touched[i] = 1'b1;
            end
        end
        if (!col_end)
            return 1'b0;
        for (int i = 0; i < NUM_RULES; i++)
        begin
            mask = rule_reg[i][accs_pkg::MASK_W-1:0];
            thr  = rule_reg[i][accs_pkg::THR_LSB +: accs_pkg::PROP_W];
            pop  = $countones(mask);
            if (!col_touched[i] || pop == 0 || col_sum[i] < thr)
                continue;
            // exact compare of sum/pop without division
            if (best < 0 || longint'(col_sum[i]) * best_pop > best_sum * pop)
            begin
                best = i;
                best_sum = col_sum[i];
                best_pop = pop;
            end
        end
        if (best < 0)
            res = '{default_sym_reg, 1'b0};
        else
            res = '{rule_reg[best][accs_pkg::SYM_LSB +: accs_pkg::SYM_W], 1'b1};
        for (int i = 0; i < NUM_RULES; i++)
        begin
            col_sum[i] = '0;
            col_touched[i] = 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_item(input logic [accs_pkg::RESIDUE_W-1:0] residue,
                             input logic [accs_pkg::PROP_W-1:0] prop,
                             input logic col_end,
                             input logic typed,
                             input consensus_t typed_res);
        consensus_t res;
        // idle gaps before an item: each further idle cycle is drawn with a chance of 31 in a hundred
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, prop, residue};
        s_tlast  <= col_end;
        @(posedge clk);
        while (!s_tready)
        begin
            stall_cycles++;
            @(posedge clk);
        end
        items_in++;
        if (consensus_step(residue, prop, col_end, res))
            pending_consensus.push_back(typed ? typed_res : res);
    endtask

    task automatic end_stream_and_settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_consensus.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all rule registers and the default symbol from the staging copy.
    task automatic load_rules();
        for (int i = 0; i <= NUM_RULES; i++)
        begin
            cfg_valid <= 1'b1;
            if (i == NUM_RULES)
            begin
                cfg_index <= accs_pkg::IDX_DEFAULT_SYM;
                cfg_data  <= accs_pkg::CFG_W'(default_next);
            end
            else
            begin
                cfg_index <= IDX_RULE0 + accs_pkg::CFG_IDX_W'(i);
                cfg_data  <= rule_next[i];
            end
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        for (int i = 0; i < NUM_RULES; i++)
            rule_reg[i] = rule_next[i];
        default_sym_reg = default_next;
        cfg_loads++;
    endtask

    task automatic stage_directed_rules(input logic [1:0] phase);
        case (phase)
            2'd1:
            begin
                rule_next[0] = make_rule(32'h0000_0003, 17'd32768, 8'h41);
                rule_next[1] = make_rule(32'hFFFF_FFFF, 17'h1FFFF, 8'hFF);  // unreachable
                rule_next[2] = make_rule(32'h0000_0000, 17'd0, 8'h00);      // empty mask
                rule_next[3] = make_rule(32'h0000_0004, 17'd0, 8'h5A);      // zero threshold
                rule_next[4] = make_rule(32'h8000_0000, 17'd65536, 8'h80);
                rule_next[5] = make_rule(32'h0000_0018, 17'd100, 8'h71);
                rule_next[6] = make_rule(32'h0000_0008, 17'd100, 8'h72);
                default_next = 8'h2E;
            end
            2'd2:
            begin
                for (int i = 0; i < NUM_RULES; i++)
                    rule_next[i] = '1;
                default_next = 8'h00;
            end
            default:
            begin
                // identical rules: lowest index must win every tie
                for (int i = 0; i < NUM_RULES; i++)
                    rule_next[i] = make_rule('1, 17'd0, accs_pkg::SYM_W'(i + 1));
                default_next = 8'hFF;
            end
        endcase
    endtask

    function automatic rule_word_t random_rule();
        logic [accs_pkg::MASK_W-1:0] mask;
        logic [accs_pkg::PROP_W-1:0] thr;
        mask = '0;
        case ($urandom_range(0, 7))
            0: mask = '0;
            1: mask = '1;
            2, 3: mask = $urandom;
            default:
                repeat ($urandom_range(1, 4)) mask[$urandom_range(0, accs_pkg::MASK_W - 1)] = 1'b1;
        endcase
        case ($urandom_range(0, 9))
            0: thr = '0;
            1: thr = accs_pkg::SUM_ONE;
            2: thr = accs_pkg::PROP_W'($urandom_range(65537, 131071));
            default: thr = accs_pkg::PROP_W'($urandom_range(0, 40000));
        endcase
        return make_rule(mask, thr, accs_pkg::SYM_W'($urandom_range(0, 255)));
    endfunction

    // Mostly residues that some rule covers, so that columns actually match.
    function automatic logic [accs_pkg::RESIDUE_W-1:0] pick_residue();
        logic [accs_pkg::MASK_W-1:0]    mask;
        logic [accs_pkg::RESIDUE_W-1:0] r;
        r = accs_pkg::RESIDUE_W'($urandom_range(0, 31));
        mask = rule_reg[$urandom_range(0, NUM_RULES - 1)][accs_pkg::MASK_W-1:0];
        if (mask != '0 && $urandom_range(0, 3) != 0)
            while (!mask[r])
                r = accs_pkg::RESIDUE_W'($urandom_range(0, 31));
        return r;
    endfunction

    function automatic logic [accs_pkg::PROP_W-1:0] pick_proportion();
        case ($urandom_range(0, 19))
            0: return accs_pkg::PROP_W'($urandom_range(0, 131071));
            1, 2: return accs_pkg::SUM_ONE;
            3, 4, 5: return accs_pkg::PROP_W'($urandom_range(0, 65536));
            default: return accs_pkg::PROP_W'($urandom_range(0, 30000));
        endcase
    endfunction

    // result side: checking, random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_consensus.size() == 0)
                begin
                    $error("unexpected result: symbol %0h matched %0b", m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want_rx = pending_consensus.pop_front();
                    if (m_tdata !== want_rx.symbol)
                    begin
                        $error("symbol: expected %0h, got %0h", want_rx.symbol, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want_rx.matched)
                    begin
                        $error("matched: expected %0b, got %0b", want_rx.matched, m_tuser);
                        errors++;
                    end
                    columns_checked++;
                    if (want_rx.matched)
                        matched_columns++;
                end
            end
            if (!hold_started && columns_checked == HOLD_AT_COLUMN)
            begin
                hold_started = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] cur_phase;
        int         sent;
        int         len;
        for (int i = 0; i < NUM_RULES; i++)
        begin
            rule_reg[i] = '0;
            col_sum[i] = '0;
            col_touched[i] = 1'b0;
        end
        default_sym_reg = accs_pkg::DEFAULT_SYM_RST;
        cur_phase = 2'd0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].phase != cur_phase)
            begin
                end_stream_and_settle();
                cur_phase = directed_rows[n].phase;
                stage_directed_rules(cur_phase);
                load_rules();
            end
            push_item(directed_rows[n].residue, directed_rows[n].prop,
                      directed_rows[n].col_end, directed_rows[n].typed,
                      directed_rows[n].want);
        end
        end_stream_and_settle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (int i = 0; i < NUM_RULES; i++)
                rule_next[i] = random_rule();
            default_next = accs_pkg::SYM_W'($urandom_range(0, 255));
            load_rules();
            calm = (ph == 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    push_item(pick_residue(), pick_proportion(), k == len - 1,
                              1'b0, '0);
                sent += len;
            end
            end_stream_and_settle();
            calm = 1'b0;
        end

        $display("Streamed %0d items; %0d column results checked, %0d by rule, %0d default.",
                 items_in, columns_checked, matched_columns,
                 columns_checked - matched_columns);
        $display("%0d rule sets loaded; input held back for %0d cycles.",
                 cfg_loads, stall_cycles);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
